// ----- rtl/clbj_pkg.sv -----
// Shared constants, register codes and types of the cable leak/break judge.
package clbj_pkg;

    localparam int DIV_W  = 46;   // dividend and quotient width of the divider
    localparam int DEN_W  = 20;   // divisor width of the divider
    localparam int DATA_W = 20;   // configuration write data width
    localparam int IDX_W  = 3;

    localparam logic [12:0] NEAR_MV = 13'd50;
    localparam logic [19:0] MEGA    = 20'd1000000;

    localparam logic [IDX_W-1:0] CFG_TOL  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ZERO = 3'd1;
    localparam logic [IDX_W-1:0] CFG_FULL = 3'd2;
    localparam logic [IDX_W-1:0] CFG_VCC  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_RS   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_R    = 3'd5;
    localparam logic [IDX_W-1:0] CFG_LEN  = 3'd6;

    // Flags that ride alongside an item through a divider.
    typedef struct packed {
        logic yel;
        logic red;
        logic leak;
        logic ok;
        logic neg;
    } t_side;

endpackage

// ----- rtl/cable_leak_break_judge.sv -----
// Top level of the cable leak/break judge: thresholds, leak location pipeline, ports.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------
//  s         | in        | i_s_tvalid / o_s_tready   | i_s_tdata, eight 12-bit mV
//  m         | out       | o_m_tvalid / i_m_tready   | o_m_tdata, flags and position
//  cfg       | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One measurement set is taken per cycle while m does not stall; each result passes
// through 101 register stages: two prep stages, a 46-stage divider pass,
// six arithmetic stages, a second 46-stage divider pass, output register.
// The dividers resolve one quotient bit per stage.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// A stall on m freezes every stage at once; nothing moves, nothing is dropped.
module cable_leak_break_judge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [11:0] black_break_mv, [23:12] yellow_break_mv, [35:24] green_break_mv,
    // [47:36] red_break_mv, [59:48] yellow_leak_mv, [71:60] green_leak_mv,
    // [83:72] red_locate_mv, [95:84] black_locate_mv
    input  logic [95:0]                   i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] yellow_loop_broken, [1] red_loop_broken, [2] any_break,
    // [3] water_present, [4] position_valid, [24:5] position_mm, [31:25] zero
    output logic [31:0]                   o_m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [clbj_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [clbj_pkg::DATA_W-1:0]   i_cfg_data
);

    // configuration registers
    logic [11:0] r_tol, r_zero, r_full, r_vcc;
    logic [15:0] r_rs;
    logic [19:0] r_r, r_len;
    logic [39:0] r_rl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= 12'd100;
            r_zero <= 12'd100;
            r_full <= 12'd3200;
            r_vcc  <= 12'd3300;
            r_rs   <= 16'd4000;
            r_r    <= 20'd10000;
            r_len  <= 20'd10000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clbj_pkg::CFG_TOL:  r_tol  <= i_cfg_data[11:0];
                clbj_pkg::CFG_ZERO: r_zero <= i_cfg_data[11:0];
                clbj_pkg::CFG_FULL: r_full <= i_cfg_data[11:0];
                clbj_pkg::CFG_VCC:  r_vcc  <= i_cfg_data[11:0];
                clbj_pkg::CFG_RS:   r_rs   <= i_cfg_data[15:0];
                clbj_pkg::CFG_R:    r_r    <= i_cfg_data;
                clbj_pkg::CFG_LEN:  r_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // r*L only follows configuration, so refresh it every cycle
    always_ff @(posedge i_clk) begin
        r_rl <= r_r * r_len;
    end

    // advance everything when the output slot is free or being taken
    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // stage A: thresholds, loop voltages, denominators
    logic [11:0] w_v1, w_v2, w_v3, w_v4, w_v5, w_v6, w_v9, w_v10;
    assign w_v1  = i_s_tdata[11:0];
    assign w_v2  = i_s_tdata[23:12];
    assign w_v3  = i_s_tdata[35:24];
    assign w_v4  = i_s_tdata[47:36];
    assign w_v5  = i_s_tdata[59:48];
    assign w_v6  = i_s_tdata[71:60];
    assign w_v9  = i_s_tdata[83:72];
    assign w_v10 = i_s_tdata[95:84];

    logic [12:0] w_d12, w_d34, w_va1, w_va2;
    logic [13:0] w_dd1, w_dd2;
    logic [11:0] w_ad12, w_ad34;
    assign w_d12  = {1'b0, w_v1} - {1'b0, w_v2};
    assign w_d34  = {1'b0, w_v3} - {1'b0, w_v4};
    assign w_ad12 = w_d12[12] ? 12'(-w_d12) : w_d12[11:0];
    assign w_ad34 = w_d34[12] ? 12'(-w_d34) : w_d34[11:0];
    assign w_va1  = {1'b0, w_v9} - {1'b0, w_v10};
    assign w_va2  = {1'b0, w_v5} - {1'b0, w_v6};
    assign w_dd1  = {w_va1[12], w_va1} - {2'b00, r_vcc};
    assign w_dd2  = {w_va2[12], w_va2} - {2'b00, r_vcc};

    logic        r_a_vld, r_a_yel, r_a_red, r_a_leak;
    logic [11:0] r_a_va1, r_a_va2;
    logic        r_a_va1n, r_a_va2n, r_a_d1n, r_a_d2n;
    logic [12:0] r_a_d1, r_a_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_yel  <= (w_ad12 > r_tol) || (w_v1 < r_zero);
            r_a_red  <= (w_ad34 > r_tol) || (w_v3 < r_zero);
            r_a_leak <= (w_v6 < r_full) || (w_v5 > r_zero);
            r_a_va1  <= w_va1[12] ? 12'(-w_va1) : w_va1[11:0];
            r_a_va2  <= w_va2[12] ? 12'(-w_va2) : w_va2[11:0];
            r_a_va1n <= w_va1[12];
            r_a_va2n <= w_va2[12];
            r_a_d1   <= w_dd1[13] ? 13'(-w_dd1) : w_dd1[12:0];
            r_a_d2   <= w_dd2[13] ? 13'(-w_dd2) : w_dd2[12:0];
            r_a_d1n  <= w_dd1[13];
            r_a_d2n  <= w_dd2[13];
        end
    end

    // stage B: Rs*|va|, early validity
    logic        r_b_vld;
    logic [27:0] r_b_m1, r_b_m2;
    logic [12:0] r_b_d1, r_b_d2;
    clbj_pkg::t_side r_b_s1, r_b_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_m1      <= r_rs * r_a_va1;
            r_b_m2      <= r_rs * r_a_va2;
            r_b_d1      <= r_a_d1;
            r_b_d2      <= r_a_d2;
            r_b_s1.yel  <= r_a_yel;
            r_b_s1.red  <= r_a_red;
            r_b_s1.leak <= r_a_leak;
            r_b_s1.ok   <= r_a_leak && (r_r != '0) &&
                           (r_a_d1 >= clbj_pkg::NEAR_MV) && (r_a_d2 >= clbj_pkg::NEAR_MV);
            r_b_s1.neg  <= r_a_va1n ^ r_a_d1n;
            r_b_s2      <= '{yel: 1'b0, red: 1'b0, leak: 1'b0, ok: 1'b0,
                             neg: r_a_va2n ^ r_a_d2n};
        end
    end

    // loop resistances in Q.16: |Rs*va| << 16 / |va - vcc|
    logic                       w_q1_vld, w_q2_vld;
    logic [clbj_pkg::DIV_W-1:0] w_q1, w_q2;
    clbj_pkg::t_side            w_q1_s, w_q2_s;

    clbj_div u_div_t1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_vld),
        .i_num   ({2'b00, r_b_m1, 16'h0000}),
        .i_den   ({7'd0, r_b_d1}),
        .i_side  (r_b_s1),
        .o_valid (w_q1_vld),
        .o_quo   (w_q1),
        .o_side  (w_q1_s)
    );

    clbj_div u_div_t2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_vld),
        .i_num   ({2'b00, r_b_m2, 16'h0000}),
        .i_den   ({7'd0, r_b_d2}),
        .i_side  (r_b_s2),
        .o_valid (w_q2_vld),
        .o_quo   (w_q2),
        .o_side  (w_q2_s)
    );

    // stage C: apply signs (|T| < 2^39)
    logic        r_c_vld;
    logic [39:0] r_c_t1, r_c_t2;
    clbj_pkg::t_side r_c_s;

    // stage D: T1 - T2 as sign and magnitude
    logic        r_d_vld, r_d_neg;
    logic [40:0] w_diff;
    logic [39:0] r_d_mag;
    clbj_pkg::t_side r_d_s;
    assign w_diff = {r_c_t1[39], r_c_t1} - {r_c_t2[39], r_c_t2};

    // stage E: 1e6 * |diff| in two halves
    logic        r_e_vld, r_e_neg;
    logic [39:0] r_e_lo, r_e_hi;
    clbj_pkg::t_side r_e_s;

    // stage F: combine halves
    logic        r_f_vld, r_f_neg;
    logic [59:0] r_f_prod;
    clbj_pkg::t_side r_f_s;

    // stage G: numerator r*L*2^16 +- 1e6*diff
    logic        r_g_vld;
    logic [61:0] r_g_num;
    clbj_pkg::t_side r_g_s;

    // stage H: range check 0 <= num <= r*L*2^17
    logic        r_h_vld;
    logic [44:0] r_h_num;
    clbj_pkg::t_side r_h_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= w_q1_vld && w_q2_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_t1   <= w_q1_s.neg ? 40'(-{1'b0, w_q1[38:0]}) : {1'b0, w_q1[38:0]};
            r_c_t2   <= w_q2_s.neg ? 40'(-{1'b0, w_q2[38:0]}) : {1'b0, w_q2[38:0]};
            r_c_s    <= w_q1_s;

            r_d_neg  <= w_diff[40];
            r_d_mag  <= w_diff[40] ? 40'(-w_diff) : w_diff[39:0];
            r_d_s    <= r_c_s;

            r_e_lo   <= r_d_mag[19:0] * clbj_pkg::MEGA;
            r_e_hi   <= r_d_mag[39:20] * clbj_pkg::MEGA;
            r_e_neg  <= r_d_neg;
            r_e_s    <= r_d_s;

            r_f_prod <= {r_e_hi, 20'd0} + {20'd0, r_e_lo};
            r_f_neg  <= r_e_neg;
            r_f_s    <= r_e_s;

            r_g_num  <= r_f_neg ? ({6'd0, r_rl, 16'd0} - {2'b00, r_f_prod})
                                : ({6'd0, r_rl, 16'd0} + {2'b00, r_f_prod});
            r_g_s    <= r_f_s;

            r_h_num  <= r_g_num[61:17];
            r_h_s    <= '{yel: r_g_s.yel, red: r_g_s.red, leak: r_g_s.leak,
                          ok: r_g_s.ok && !r_g_num[61] &&
                              (r_g_num <= {5'd0, r_rl, 17'd0}),
                          neg: 1'b0};
        end
    end

    // position = floor((num >> 17) / r)
    logic                       w_p_vld;
    logic [clbj_pkg::DIV_W-1:0] w_p;
    clbj_pkg::t_side            w_p_s;

    clbj_div u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_h_vld),
        .i_num   ({1'b0, r_h_num}),
        .i_den   (r_r),
        .i_side  (r_h_s),
        .o_valid (w_p_vld),
        .o_quo   (w_p),
        .o_side  (w_p_s)
    );

    // output register
    logic        r_o_vld;
    logic [31:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= w_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= {7'd0,
                         w_p_s.ok ? w_p[19:0] : 20'd0,
                         w_p_s.ok,
                         w_p_s.leak,
                         w_p_s.yel || w_p_s.red,
                         w_p_s.red,
                         w_p_s.yel};
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;

    // a located leak is always a leak
    a_pos_needs_leak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[4]) |-> o_m_tdata[3])
        else $error("position valid without leak");

    // no position reported when location failed
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[4]) |-> (o_m_tdata[24:5] == 20'd0))
        else $error("position nonzero while invalid");

    // a located leak lies on the cable
    a_pos_in_cable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[4]) |-> (o_m_tdata[24:5] <= r_len))
        else $error("position beyond cable length");

    // both resistance dividers stay in step
    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q1_vld == w_q2_vld)
        else $error("divider lanes out of step");

endmodule

// ----- rtl/clbj_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a flag sideband.
module clbj_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [clbj_pkg::DIV_W-1:0]      i_num,
    input  logic [clbj_pkg::DEN_W-1:0]      i_den,
    input  clbj_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [clbj_pkg::DIV_W-1:0]      o_quo,
    output clbj_pkg::t_side                 o_side
);

    localparam int N = clbj_pkg::DIV_W;
    localparam int D = clbj_pkg::DEN_W;

    logic            r_vld  [N];
    logic [N-1:0]    r_w    [N];
    logic [D-1:0]    r_rem  [N];
    logic [D-1:0]    r_den  [N];
    clbj_pkg::t_side r_side [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic            w_vld;
            logic [N-1:0]    w_w;
            logic [D-1:0]    w_rem;
            logic [D-1:0]    w_den;
            clbj_pkg::t_side w_side;
            logic [D:0]      w_trial;
            logic [D:0]      w_diff;
            logic            w_ge;

            if (k == 0) begin : g_first
                assign w_vld  = i_valid;
                assign w_w    = i_num;
                assign w_rem  = '0;
                assign w_den  = i_den;
                assign w_side = i_side;
            end else begin : g_next
                assign w_vld  = r_vld[k-1];
                assign w_w    = r_w[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_den  = r_den[k-1];
                assign w_side = r_side[k-1];
            end

            assign w_trial = {w_rem, w_w[N-1]};
            assign w_diff  = w_trial - {1'b0, w_den};
            assign w_ge    = (w_trial >= {1'b0, w_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_w[k]    <= {w_w[N-2:0], w_ge};
                    r_rem[k]  <= w_ge ? w_diff[D-1:0] : w_trial[D-1:0];
                    r_den[k]  <= w_den;
                    r_side[k] <= w_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_w[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- tb/sv/cable_leak_break_judge_chk.sv -----
// Checker for the cable leak/break judge: tracks registers, predicts and compares results.
`timescale 1ns / 1ps
module cable_leak_break_judge_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [95:0]                   i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [31:0]                   i_m_tdata,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [clbj_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [clbj_pkg::DATA_W-1:0]   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [6:0]  pad;
        logic [19:0] pos_mm;
        logic        pos_ok;
        logic        leak;
        logic        any_brk;
        logic        red_brk;
        logic        yel_brk;
    } t_verdict;

    logic [11:0] tol_mv, zero_mv, full_mv, vcc_mv;
    logic [15:0] rs_ohm;
    logic [19:0] r_mohm, len_mm;

    t_verdict verdict_q[$];

    // Loop resistance in ohms Q.16; zero return when the divisor is too close to zero.
    function automatic bit loop_ohms_q16(input longint va, output longint t);
        longint d;
        d = va - longint'(vcc_mv);
        t = 0;
        if (d < 50 && d > -50) return 0;
        t = (longint'(rs_ohm) * va * 65536) / d;
        return 1;
    endfunction

    function automatic t_verdict judge_set(input logic [95:0] d);
        longint v[8];
        longint t1, t2, num, den, r, len;
        t_verdict res;
        for (int i = 0; i < 8; i++) v[i] = longint'(d[12*i +: 12]);
        res = '0;
        res.yel_brk = ((v[0] > v[1] ? v[0] - v[1] : v[1] - v[0]) > tol_mv) || (v[0] < zero_mv);
        res.red_brk = ((v[2] > v[3] ? v[2] - v[3] : v[3] - v[2]) > tol_mv) || (v[2] < zero_mv);
        res.any_brk = res.yel_brk | res.red_brk;
        res.leak    = (v[5] < full_mv) || (v[4] > zero_mv);
        r   = longint'(r_mohm);
        len = longint'(len_mm);
        // Locate only on a leak, with a usable resistance and both divisors clear of zero.
        if (res.leak && r != 0 && loop_ohms_q16(v[6] - v[7], t1) &&
            loop_ohms_q16(v[4] - v[5], t2)) begin
            num = r * len * 65536 + 64'sd1000000 * (t1 - t2);
            den = 2 * r * 65536;
            if (num >= 0 && num <= len * den) begin
                res.pos_ok = 1'b1;
                res.pos_mm = 20'(num / den);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want, got;
        if (!i_rst_n) begin
            tol_mv <= 12'd100;
            zero_mv <= 12'd100;
            full_mv <= 12'd3200;
            vcc_mv <= 12'd3300;
            rs_ohm <= 16'd4000;
            r_mohm <= 20'd10000;
            len_mm <= 20'd10000;
            verdict_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) verdict_q.push_back(judge_set(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
                        $display("    pos_mm exp %0d act %0d, flags exp %b act %b",
                                 want.pos_mm, got.pos_mm, want[4:0], got[4:0]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // Apply a register write after this edge's prediction.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    clbj_pkg::CFG_TOL:  tol_mv  <= i_cfg_data[11:0];
                    clbj_pkg::CFG_ZERO: zero_mv <= i_cfg_data[11:0];
                    clbj_pkg::CFG_FULL: full_mv <= i_cfg_data[11:0];
                    clbj_pkg::CFG_VCC:  vcc_mv  <= i_cfg_data[11:0];
                    clbj_pkg::CFG_RS:   rs_ohm  <= i_cfg_data[15:0];
                    clbj_pkg::CFG_R:    r_mohm  <= i_cfg_data;
                    clbj_pkg::CFG_LEN:  len_mm  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_pending = verdict_q.size();

endmodule

// ----- tb/sv/cable_leak_break_judge_tb.sv -----
// Top of the cable leak/break judge testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module cable_leak_break_judge_tb;

    localparam int STALL_LIMIT = 20000;   // cycles without any transfer

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [95:0]                     s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [31:0]                     m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [clbj_pkg::IDX_W-1:0]      cfg_index = '0;
    logic [clbj_pkg::DATA_W-1:0]     cfg_data = '0;
    int                              fail_count;
    int                              pending;
    bit                              idling_on = 1'b1;
    int                              quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    cable_leak_break_judge uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    cable_leak_break_judge_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: drop ready at random with a probability of 38 percent unless idling is off.
    always @(negedge i_clk)
        m_tready <= idling_on ? ($urandom_range(99) >= 38) : 1'b1;

    // Watchdog: abort when nothing has transferred for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one measurement set and hold it until the transfer; valid stays high on return.
    task automatic send_set(input logic [95:0] d);
        while (idling_on && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write one register; valid stays high on return so back-to-back writes are clean.
    task automatic write_reg(input logic [clbj_pkg::IDX_W-1:0] idx,
                             input logic [clbj_pkg::DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every result is back, then let the pipeline settle.
    task automatic drain;
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic load_regs(input int tol, input int zero, input int full, input int vcc,
                             input int rs, input int r, input int len);
        write_reg(clbj_pkg::CFG_TOL, clbj_pkg::DATA_W'(tol));
        write_reg(clbj_pkg::CFG_ZERO, clbj_pkg::DATA_W'(zero));
        write_reg(clbj_pkg::CFG_FULL, clbj_pkg::DATA_W'(full));
        write_reg(clbj_pkg::CFG_VCC, clbj_pkg::DATA_W'(vcc));
        write_reg(clbj_pkg::CFG_RS, clbj_pkg::DATA_W'(rs));
        write_reg(clbj_pkg::CFG_R, clbj_pkg::DATA_W'(r));
        write_reg(clbj_pkg::CFG_LEN, clbj_pkg::DATA_W'(len));
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [95:0] pack_set(input int v1, input int v2, input int v3,
                                             input int v4, input int v5, input int v6,
                                             input int v9, input int v10);
        return {12'(v10), 12'(v9), 12'(v6), 12'(v5), 12'(v4), 12'(v3), 12'(v2), 12'(v1)};
    endfunction

    function automatic int clip_mv(input int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // Mostly plausible leak sets with small loop differences so positions land on the
    // cable; the rest is uniform noise over all bits.
    function automatic logic [95:0] random_set;
        int v1, v3, v6, v10, spread;
        if ($urandom_range(99) < 25) return {$urandom, $urandom, $urandom};
        spread = ($urandom_range(3) == 0) ? 600 : 80;
        v1  = $urandom_range(4095);
        v3  = $urandom_range(4095);
        v6  = $urandom_range(4095);
        v10 = $urandom_range(4095);
        return pack_set(v1, clip_mv(v1 + $urandom_range(300) - 150),
                        v3, clip_mv(v3 + $urandom_range(300) - 150),
                        clip_mv(v6 + $urandom_range(2 * spread) - spread), v6,
                        clip_mv(v10 + $urandom_range(2 * spread) - spread), v10);
    endfunction

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed sets under reset registers.
        send_set(pack_set(0, 0, 0, 0, 0, 0, 0, 0));
        send_set(pack_set(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send_set(pack_set(1000, 1100, 1000, 1101, 0, 3300, 0, 0));    // loops at tolerance edge
        send_set(pack_set(99, 99, 100, 100, 100, 3200, 0, 0));        // return below zero level
        send_set(pack_set(2000, 2000, 2000, 2000, 101, 3300, 50, 0)); // leak from yellow side
        send_set(pack_set(2000, 2000, 2000, 2000, 0, 3199, 20, 30));  // leak from green side
        send_set(pack_set(2000, 2000, 2000, 2000, 3300, 0, 10, 0));   // divisor near zero
        send_set(pack_set(2000, 2000, 2000, 2000, 0, 100, 3260, 0));  // divisor still too near zero
        send_set(pack_set(2000, 2000, 2000, 2000, 4095, 0, 0, 4095)); // far out of cable
        send_set(pack_set(2000, 2000, 2000, 2000, 60, 0, 0, 60));     // just past one end
        send_set(pack_set(2000, 2000, 2000, 2000, 5, 0, 5, 0));       // middle of the cable
        send_set(pack_set(4095, 0, 0, 4095, 0, 4095, 4095, 0));
        drain();

        // Zero resistance, then the low and high extremes of every register.
        load_regs(100, 100, 3200, 3300, 4000, 0, 10000);
        send_set(pack_set(2000, 2000, 2000, 2000, 5, 0, 5, 0));
        send_set(pack_set(2000, 2000, 2000, 2000, 0, 1000, 0, 0));
        drain();
        load_regs(0, 0, 0, 0, 0, 0, 0);
        send_set(pack_set(5, 5, 0, 0, 0, 0, 0, 0));
        send_set(pack_set(5, 6, 7, 7, 1, 0, 1, 0));
        drain();
        load_regs(4095, 4095, 4095, 4095, 65535, 1000000, 1000000);
        send_set(pack_set(0, 4095, 4095, 4095, 4095, 0, 4095, 0));
        send_set(pack_set(4095, 0, 0, 0, 10, 0, 20, 0));
        send_set(pack_set(0, 0, 0, 0, 0, 4095, 0, 4095));
        drain();
        // All-ones data is cut to each register's width; an unused index is ignored.
        load_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        write_reg(3'd7, 20'hFFFFF);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
        send_set(pack_set(100, 100, 100, 100, 50, 0, 100, 0));
        drain();

        // Random phases; one runs without any idling on either side.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0)
                load_regs(100, 100, 3200, 3300, 4000, 10000, 10000);
            else
                load_regs($urandom_range(300), $urandom_range(400), $urandom_range(2500, 4095),
                          $urandom_range(1, 4095), $urandom_range(1, 65535),
                          ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 1000000),
                          $urandom_range(1, 1000000));
            idling_on = (ph != 3);
            for (int n = 0; n < 80; n++) send_set(random_set());
            drain();
        end
        idling_on = 1'b1;

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
